// File: rtl/core/bmul_pkg.sv
// Shared constants for the radix-2 Booth multiplier.
// Used by bmul_cell, booth_multiplier_16bit_unit and the testbench files; depends on nothing.
package bmul_pkg;

  // Width of the operand fields on the input ports
  localparam int FieldWidth = 16;
  // Width of the product field on the output port
  localparam int ProductWidth = 32;
  // Default number of Booth steps and width of A and Q
  localparam int OperandWidthDef = 16;

  // Booth recoding of the pair (Q0, Q-1)
  localparam logic [1:0] BoothSub = 2'b10;
  localparam logic [1:0] BoothAdd = 2'b01;

endpackage

// File: rtl/core/bmul_cell.sv
// One Booth step with its own pipeline register and valid/ready handshake.
// Depends on bmul_pkg for the recoding codes and the default width.
module bmul_cell #(
  parameter int OPERAND_WIDTH = bmul_pkg::OperandWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [OPERAND_WIDTH-1:0] a_i,
  input  logic [OPERAND_WIDTH-1:0] q_i,
  input  logic                     q1_i,
  input  logic [OPERAND_WIDTH-1:0] m_i,
  input  logic                     err_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [OPERAND_WIDTH-1:0] a_o,
  output logic [OPERAND_WIDTH-1:0] q_o,
  output logic                     q1_o,
  output logic [OPERAND_WIDTH-1:0] m_o,
  output logic                     err_o
);

  logic                     valid_q;
  logic [OPERAND_WIDTH-1:0] a_q, q_q, m_q;
  logic                     q1_q, err_q;
  logic [OPERAND_WIDTH-1:0] sum;
  logic [OPERAND_WIDTH-1:0] a_d, q_d;
  logic                     load;

  // Add or subtract the multiplicand as the low pair asks
  always_comb begin
    case ({q_i[0], q1_i})
      bmul_pkg::BoothSub: sum = a_i - m_i;
      bmul_pkg::BoothAdd: sum = a_i + m_i;
      default:            sum = a_i;
    endcase
  end

  // Shift A:Q:Q-1 right, keeping the sign of A
  assign a_d = {sum[OPERAND_WIDTH-1], sum[OPERAND_WIDTH-1:1]};
  assign q_d = {sum[0], q_i[OPERAND_WIDTH-1:1]};

  // Take a new word when the register is empty or drains this cycle
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold the word until the next cell takes it
  always_ff @(posedge clk_i) begin
    if (load) begin
      a_q   <= a_d;
      q_q   <= q_d;
      q1_q  <= q_i[0];
      m_q   <= m_i;
      err_q <= err_i;
    end
  end

  assign valid_o = valid_q;
  assign a_o     = a_q;
  assign q_o     = q_q;
  assign q1_o    = q1_q;
  assign m_o     = m_q;
  assign err_o   = err_q;

endmodule

// File: rtl/core/booth_multiplier_16bit_unit.sv
// Top level of the radix-2 Booth multiplier: range check, chain of step cells.
// Depends on bmul_pkg and bmul_cell.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries a word of two signed
//   16-bit operands, multiplier_i and multiplicand_i. Output channel
//   (out_valid_o / out_ready_i) carries the signed 32-bit product_o and
//   range_error_o. An operand outside +/-(2^(OPERAND_WIDTH-1)-1) gives
//   range_error_o = 1 and product_o = 0; at the default width only -32768
//   is rejected.
//   Each operand word passes through the chain of cells in order, one
//   Booth step per cell, each cell with its own register; out_valid_o
//   rises once the last cell has registered the word. Throughput: one
//   word per cycle unless the output stalls; every cell holds one word,
//   so up to OPERAND_WIDTH words are in flight.
//   Stall: when out_ready_i is low the last cell holds its word; words
//   behind it close up into empty cells, and in_ready_o drops only once
//   every cell is full.
//   Reset: rst_ni clears all valid bits; the chain comes up empty and
//   in_ready_o is high.
module booth_multiplier_16bit_unit #(
  parameter int OPERAND_WIDTH = bmul_pkg::OperandWidthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [bmul_pkg::FieldWidth-1:0]   multiplier_i,
  input  logic signed [bmul_pkg::FieldWidth-1:0]   multiplicand_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [bmul_pkg::ProductWidth-1:0] product_o,
  output logic                               range_error_o
);

  localparam int W  = OPERAND_WIDTH;
  localparam int FW = bmul_pkg::FieldWidth;
  localparam int PW = bmul_pkg::ProductWidth;

  // Per-stage word; index 0 is the input, index W the last cell
  logic         valid_s [0:W];
  logic         ready_s [0:W];
  logic [W-1:0] a_s     [0:W];
  logic [W-1:0] q_s     [0:W];
  logic         q1_s    [0:W];
  logic [W-1:0] m_s     [0:W];
  logic         err_s   [0:W];

  logic         err_in;
  logic [W-1:0] q_init, m_init;
  logic [2*W-1:0] aq;

  // Fit operands to W bits and check their range
  if (W > FW) begin : g_wide
    assign q_init = {{(W-FW){multiplier_i[FW-1]}}, multiplier_i};
    assign m_init = {{(W-FW){multiplicand_i[FW-1]}}, multiplicand_i};
    assign err_in = 1'b0;
  end else begin : g_narrow
    logic [FW-W:0] hi_q, hi_m;
    logic          bad_q, bad_m;

    assign q_init = multiplier_i[W-1:0];
    assign m_init = multiplicand_i[W-1:0];
    assign hi_q   = multiplier_i[FW-1:W-1];
    assign hi_m   = multiplicand_i[FW-1:W-1];

    // Out of range: top bits not a sign extension, or the most negative value
    assign bad_q = !(hi_q == '0 || hi_q == '1) ||
                   (hi_q == '1 && multiplier_i[W-2:0] == '0);
    assign bad_m = !(hi_m == '0 || hi_m == '1) ||
                   (hi_m == '1 && multiplicand_i[W-2:0] == '0);
    assign err_in = bad_q || bad_m;
  end

  // Seed the chain: A = 0, Q = multiplier, Q-1 = 0
  assign valid_s[0] = in_valid_i;
  assign in_ready_o = ready_s[0];
  assign a_s[0]     = '0;
  assign q_s[0]     = q_init;
  assign q1_s[0]    = 1'b0;
  assign m_s[0]     = m_init;
  assign err_s[0]   = err_in;

  // One cell per Booth step
  for (genvar k = 0; k < W; k++) begin : g_cell
    bmul_cell #(
      .OPERAND_WIDTH(W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_s[k]),
      .ready_o(ready_s[k]),
      .a_i    (a_s[k]),
      .q_i    (q_s[k]),
      .q1_i   (q1_s[k]),
      .m_i    (m_s[k]),
      .err_i  (err_s[k]),
      .valid_o(valid_s[k+1]),
      .ready_i(ready_s[k+1]),
      .a_o    (a_s[k+1]),
      .q_o    (q_s[k+1]),
      .q1_o   (q1_s[k+1]),
      .m_o    (m_s[k+1]),
      .err_o  (err_s[k+1])
    );
  end

  // Drive the output word from the last cell
  assign ready_s[W]    = out_ready_i;
  assign out_valid_o   = valid_s[W];
  assign range_error_o = err_s[W];
  assign aq            = {a_s[W], q_s[W]};

  if (2*W >= PW) begin : g_prod_trunc
    assign product_o = err_s[W] ? '0 : aq[PW-1:0];
  end else begin : g_prod_ext
    assign product_o = err_s[W] ? '0 : {{(PW-2*W){1'b0}}, aq};
  end

`ifndef SYNTH
  // A full chain is the only reason to refuse input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while chain can advance");

  // Drained output with nothing behind it leaves the output empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !valid_s[W-1]) |=> !out_valid_o)
    else $error("output word repeated");

  // Rejected operands yield a zero product
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |-> (product_o == '0))
    else $error("range error with nonzero product");

  // Stalled output word keeps its error flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(range_error_o)))
    else $error("stalled output word changed");
`endif

endmodule

// File: tb/booth_product_checker.sv
// Checker for the radix-2 Booth multiplier: watches both channels, predicts
// each product and compares it. Depends on bmul_pkg.
`timescale 1ns / 100ps

module booth_product_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic                                   in_ready_i,
  input  logic signed [bmul_pkg::FieldWidth-1:0]   multiplier_i,
  input  logic signed [bmul_pkg::FieldWidth-1:0]   multiplicand_i,
  input  logic                                   out_valid_i,
  input  logic                                   out_ready_i,
  input  logic signed [bmul_pkg::ProductWidth-1:0] product_i,
  input  logic                                   range_error_i,
  output int                                     err_count_o,
  output int                                     pending_o,
  output int                                     checked_o,
  output int                                     rejected_o
);

  localparam int StepCount = bmul_pkg::OperandWidthDef;

  typedef struct packed {
    logic signed [bmul_pkg::ProductWidth-1:0] product;
    logic                                     range_error;
  } product_word_t;

  // Expected output words, oldest first
  product_word_t expected_products[$];

  // Run the Booth steps on A:Q:Q-1 and reject operands out of range
  function automatic product_word_t booth_product(
    input logic signed [bmul_pkg::FieldWidth-1:0] mq,
    input logic signed [bmul_pkg::FieldWidth-1:0] mc
  );
    int                       lim;
    logic [StepCount-1:0]     acc;
    logic [StepCount-1:0]     qreg;
    logic [StepCount-1:0]     mreg;
    logic                     q_prev;
    logic [2*StepCount-1:0]   joined;
    product_word_t            res;
    lim = (1 << (StepCount - 1)) - 1;
    res = '0;
    if (int'(mq) > lim || int'(mq) < -lim || int'(mc) > lim || int'(mc) < -lim) begin
      res.range_error = 1'b1;
      return res;
    end
    acc    = '0;
    qreg   = StepCount'(mq);
    mreg   = StepCount'(mc);
    q_prev = 1'b0;
    for (int i = 0; i < StepCount; i++) begin
      case ({qreg[0], q_prev})
        bmul_pkg::BoothSub: acc = acc - mreg;
        bmul_pkg::BoothAdd: acc = acc + mreg;
        default: ;
      endcase
      q_prev = qreg[0];
      qreg   = {acc[0], qreg[StepCount-1:1]};
      // arithmetic shift keeps the sign of A
      acc    = {acc[StepCount-1], acc[StepCount-1:1]};
    end
    joined = {acc, qreg};
    res.product = joined[bmul_pkg::ProductWidth-1:0];
    return res;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    err_count_o++;
  endtask

  initial begin
    err_count_o = 0;
    pending_o   = 0;
    checked_o   = 0;
    rejected_o  = 0;
  end

  // Compare each accepted output word, then queue the prediction for a new input word
  always @(posedge clk_i or negedge rst_ni) begin
    product_word_t want;
    if (!rst_ni) begin
      expected_products.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_products.size() == 0) begin
          report_mismatch($sformatf("output word %0d / %0b with nothing expected",
                                    product_i, range_error_i));
        end else begin
          want = expected_products.pop_front();
          checked_o++;
          if (range_error_i) rejected_o++;
          if (product_i !== want.product)
            report_mismatch($sformatf("product %0d, expected %0d", product_i, want.product));
          if (range_error_i !== want.range_error)
            report_mismatch($sformatf("range_error %0b, expected %0b",
                                      range_error_i, want.range_error));
        end
      end
      if (in_valid_i && in_ready_i)
        expected_products.push_back(booth_product(multiplier_i, multiplicand_i));
      pending_o = expected_products.size();
    end
  end

endmodule

// File: tb/tb_booth_multiplier_16bit_unit.sv
// Testbench top for booth_multiplier_16bit_unit: clock, reset, operand stimulus,
// random stalls and the verdict. Depends on bmul_pkg and booth_product_checker.
`timescale 1ns / 100ps

module tb_booth_multiplier_16bit_unit;

  localparam int RandomWords = 650;
  localparam int QuietTail   = 80;
  localparam int StallLimit  = 2000;

  logic                                   clk_i;
  logic                                   rst_ni;
  logic                                   in_valid_i;
  logic                                   in_ready_o;
  logic signed [bmul_pkg::FieldWidth-1:0]   multiplier_i;
  logic signed [bmul_pkg::FieldWidth-1:0]   multiplicand_i;
  logic                                   out_valid_o;
  logic                                   out_ready_i;
  logic signed [bmul_pkg::ProductWidth-1:0] product_o;
  logic                                   range_error_o;

  int err_count;
  int pending;
  int checked;
  int rejected;
  int words_sent;
  int directed_sent;
  int idle_cycles;
  bit allow_idle;

  logic signed [bmul_pkg::FieldWidth-1:0] edge_vals [8] = '{
    16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32767, -16'sd32768, 16'sd16384, -16'sd16384
  };

  booth_multiplier_16bit_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .multiplier_i   (multiplier_i),
    .multiplicand_i (multiplicand_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .product_o      (product_o),
    .range_error_o  (range_error_o)
  );

  booth_product_checker u_product_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .multiplier_i   (multiplier_i),
    .multiplicand_i (multiplicand_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .product_i      (product_o),
    .range_error_i  (range_error_o),
    .err_count_o    (err_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .rejected_o     (rejected)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Drive one operand word; hold valid and payload until accepted
  task automatic send_word(input logic signed [bmul_pkg::FieldWidth-1:0] mq,
                           input logic signed [bmul_pkg::FieldWidth-1:0] mc);
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    multiplier_i   <= mq;
    multiplicand_i <= mc;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    words_sent++;
  endtask

  // Receiver: drop ready in random bursts while idling is allowed
  always begin
    @(negedge clk_i);
    if (rst_ni && allow_idle && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Timeout: no word accepted for %0d cycles, %0d still expected",
               StallLimit, pending);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int pick;
    logic signed [bmul_pkg::FieldWidth-1:0] mq;
    logic signed [bmul_pkg::FieldWidth-1:0] mc;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    multiplier_i   = '0;
    multiplicand_i = '0;
    out_ready_i    = 1'b1;
    allow_idle     = 1'b1;
    words_sent     = 0;
    idle_cycles    = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, rejected operands, sign mixes, Booth transitions
    send_word(16'sd0, 16'sd0);
    send_word(16'sd32767, 16'sd32767);
    send_word(-16'sd32767, -16'sd32767);
    send_word(16'sd32767, -16'sd32767);
    send_word(-16'sd32767, 16'sd32767);
    send_word(-16'sd32768, 16'sd5);
    send_word(16'sd5, -16'sd32768);
    send_word(-16'sd32768, -16'sd32768);
    send_word(-16'sd32768, 16'sd0);
    send_word(16'sd0, -16'sd32768);
    send_word(16'sd1, -16'sd1);
    send_word(-16'sd1, -16'sd1);
    send_word(16'sd1, 16'sd0);
    send_word(16'sd0, 16'sd1);
    send_word(16'sh5555, 16'sh2AAA);
    send_word(-16'sh5556, 16'sh5555);
    send_word(16'sh7FFE, 16'sh0101);
    send_word(16'sd16384, -16'sd2);
    send_word(-16'sd16384, -16'sd16384);
    send_word(16'sh00FF, -16'sh0100);
    directed_sent = words_sent;

    // Random: mostly full-range operands, some edge values and rejects
    for (int i = 0; i < RandomWords; i++) begin
      if (i == RandomWords - QuietTail) allow_idle = 1'b0;
      pick = $urandom_range(0, 15);
      mq = 16'($urandom);
      mc = 16'($urandom);
      if (pick == 0) begin
        mq = -16'sd32768;
      end else if (pick == 1) begin
        mc = -16'sd32768;
      end else if (pick == 2) begin
        mq = edge_vals[3'($urandom_range(0, 7))];
        mc = edge_vals[3'($urandom_range(0, 7))];
      end else if (pick <= 4) begin
        mq = 16'($urandom_range(0, 31) - 16);
        mc = 16'($urandom_range(0, 31) - 16);
      end
      send_word(mq, mc);
    end
    in_valid_i <= 1'b0;

    // Drain, then watch a while for stray output words
    while (pending != 0) @(negedge clk_i);
    repeat (bmul_pkg::OperandWidthDef + 8) @(negedge clk_i);

    $display("Run covered %0d operand words (%0d directed), %0d products compared,",
             words_sent, directed_sent, checked);
    $display("%0d of them flagged out of range, with random stalls on both channels.",
             rejected);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
